// ===== sv/ssao_pkg.sv =====
// Shared types, constants and the per-neighbour angle term tables for the occlusion block.
package ssao_pkg;

	localparam int FRAC_BITS = 16;
	localparam int TERM_W = FRAC_BITS - 2;
	localparam int NB_COUNT = 8;
	localparam int ATAN_ITERS = 30;

	typedef logic [TERM_W-1:0] term_t;
	typedef logic [FRAC_BITS-1:0] frac_t;
	typedef logic [FRAC_BITS:0] unit_t;
	typedef logic [255:0][TERM_W-1:0] term_table_t;

	localparam logic [63:0] ONE64 = 64'd1 << FRAC_BITS;
	localparam logic [63:0] EIGHTH64 = ONE64 >> 3;
	localparam logic [63:0] LO64 = (ONE64 * 64'd5 + 64'd50) / 64'd100;
	localparam logic [63:0] HI64 = (ONE64 * 64'd95 + 64'd50) / 64'd100;
	localparam logic [63:0] SPAN64 = HI64 - LO64;
	localparam logic [63:0] RECIP64 = (64'd1 << (2 * FRAC_BITS)) / SPAN64;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] SQRT2_Q30 = 64'd1518500250;
	localparam logic [63:0] ATAN_DEN = 64'd4 * PI_Q30;

	localparam unit_t ONE = unit_t'(ONE64);
	localparam term_t EIGHTH = term_t'(EIGHTH64);
	localparam unit_t EDGE_LO = unit_t'(LO64);
	localparam unit_t EDGE_HI = unit_t'(HI64);
	localparam frac_t EDGE_SPAN = frac_t'(SPAN64);
	localparam unit_t EDGE_RECIP = unit_t'(RECIP64);
	localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS + 2)'(ONE64 * 64'd3);

	// Neighbours at a diagonal offset, bit i for the i-th listed neighbour.
	localparam logic [NB_COUNT-1:0] NB_DIAG = 8'b1010_0101;

	localparam logic [31:0] ATAN_STEPS [ATAN_ITERS] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
		32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
		32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
		32'd32, 32'd16, 32'd8, 32'd4, 32'd2
	};

	// Builds the term table for one distance class by CORDIC vectoring; evaluated
	// only while the design elaborates.
	function automatic term_table_t build_terms(input logic diag);
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic signed [63:0] z;
		logic signed [63:0] xs;
		logic signed [63:0] ys;
		logic [63:0] a;
		logic [63:0] an;
		term_table_t t;
		t = '0;
		for (int d = 0; d < 256; d++) begin
			x = diag ? 64'd255 * SQRT2_Q30 : 64'd255 << 30;
			y = 64'(d) << 30;
			z = '0;
			for (int i = 0; i < ATAN_ITERS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (!y[63]) begin
					x = x + ys;
					y = y - xs;
					z = z + 64'(ATAN_STEPS[i]);
				end else begin
					x = x - ys;
					y = y + xs;
					z = z - 64'(ATAN_STEPS[i]);
				end
			end
			a = z[63] ? 64'd0 : 64'(z);
			an = ((a << FRAC_BITS) + ATAN_DEN / 64'd2) / ATAN_DEN;
			t[d] = (an > EIGHTH64) ? '0 : term_t'(EIGHTH64 - an);
		end
		return t;
	endfunction

	localparam term_table_t EDGE_TERMS = build_terms(1'b0);
	localparam term_table_t DIAG_TERMS = build_terms(1'b1);

	// Fixed-point product of two unit-range values.
	function automatic unit_t mulq(input unit_t a, input unit_t b);
		logic [2*FRAC_BITS+1:0] p;
		p = (2 * FRAC_BITS + 2)'(a) * (2 * FRAC_BITS + 2)'(b);
		return p[FRAC_BITS +: FRAC_BITS + 1];
	endfunction

endpackage

// ===== sv/ssao_depth_window_occlusion_top.sv =====
// Top level of the 3x3 depth window ambient occlusion pipeline.
//
// Usage: each input transaction carries one pixel's centre depth, its eight
// neighbour depths and a mask of the neighbours that lie inside the frame.
// Each input transaction yields exactly one output transaction carrying the
// occlusion grey level, in the same order as the inputs arrived.
// Throughput is one transaction per cycle while out_ready is high. The
// pipeline has seventeen stages, and each stage holds at most one multiplier.
// The angle terms come from two constant tables of 256 entries (edge and
// diagonal neighbours), read once per neighbour in the first stage.
// Every stage has its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and in_ready stays high while
// a finished result waits, as long as some stage is empty.
// When out_ready is low, the last stage holds its result and the stages
// behind it fill up; no transaction is lost or repeated.
// Reset (arst_n low) clears all valid bits at once; the pipeline is empty
// and ready for input in the first cycle after reset is released.
module ssao_depth_window_occlusion_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] center_depth,
	input  logic [7:0] depth_up_left,
	input  logic [7:0] depth_up,
	input  logic [7:0] depth_up_right,
	input  logic [7:0] depth_left,
	input  logic [7:0] depth_right,
	input  logic [7:0] depth_down_left,
	input  logic [7:0] depth_down,
	input  logic [7:0] depth_down_right,
	input  logic [7:0] neighbour_present,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] occlusion
);
	import ssao_pkg::*;

	localparam int NUM_STAGES = 17;

	// Per-stage valid bits and the advance chain that moves each stage.
	logic [NUM_STAGES:1] vld_q;
	logic [NUM_STAGES+1:1] adv;

	// Stage 1: per-neighbour angle terms.
	logic [7:0] nb_depth [NB_COUNT];
	term_t term_next [NB_COUNT];
	term_t term_s1 [NB_COUNT];
	// Stage 2: summed terms.
	unit_t total_s2;
	// Stages 3 to 10: power of 100 by repeated squaring.
	unit_t x2_s3, x4_s4, x8_s5, x16_s6, x32_s7, x64_s8, m_s9, p_s10;
	unit_t x4_s5, x4_s6, x4_s7, x4_s8, x4_s9;
	unit_t x32_s8;
	// Stages 11 to 14: normalization into the smoothstep window.
	frac_t n_s11, n_s12, n_s13;
	logic lo_s11, lo_s12, lo_s13, lo_s14, lo_s15;
	logic hi_s11, hi_s12, hi_s13, hi_s14, hi_s15;
	frac_t q0_s12, q0_s13;
	logic [2*FRAC_BITS-1:0] qd_s13;
	logic [2*FRAC_BITS-1:0] rem_next;
	frac_t u_s14;
	// Stages 15 to 17: smoothstep polynomial and output scaling.
	frac_t uu_s15;
	logic [FRAC_BITS+1:0] w_s15;
	unit_t s_s16;
	logic [7:0] level_s17;

	logic [2*FRAC_BITS:0] q0_prod;
	logic [2*FRAC_BITS-1:0] uu_prod;
	logic [2*FRAC_BITS+1:0] s_prod;
	logic [FRAC_BITS+8:0] lvl_prod;

	always_comb begin
		adv[NUM_STAGES+1] = out_ready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign in_ready = adv[1];
	assign out_valid = vld_q[NUM_STAGES];
	assign occlusion = level_s17;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NUM_STAGES; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// A present neighbour that is not deeper than the centre gives the full eighth;
	// a deeper one reads its term from the table of its distance class. An absent
	// neighbour gives zero; a background centre zeroes all terms, driving the output to 0.
	always_comb begin
		nb_depth[0] = depth_up_left;
		nb_depth[1] = depth_up;
		nb_depth[2] = depth_up_right;
		nb_depth[3] = depth_left;
		nb_depth[4] = depth_right;
		nb_depth[5] = depth_down_left;
		nb_depth[6] = depth_down;
		nb_depth[7] = depth_down_right;
		for (int i = 0; i < NB_COUNT; i++) begin
			if (!neighbour_present[i] || center_depth == 8'd0) begin
				term_next[i] = '0;
			end else if (nb_depth[i] <= center_depth) begin
				term_next[i] = EIGHTH;
			end else if (NB_DIAG[i]) begin
				term_next[i] = DIAG_TERMS[nb_depth[i] - center_depth];
			end else begin
				term_next[i] = EDGE_TERMS[nb_depth[i] - center_depth];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			term_s1 <= term_next;
		end
	end

	// Eight terms of at most one eighth each never exceed one.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			total_s2 <= ((unit_t'(term_s1[0]) + unit_t'(term_s1[1]))
				+ (unit_t'(term_s1[2]) + unit_t'(term_s1[3])))
				+ ((unit_t'(term_s1[4]) + unit_t'(term_s1[5]))
				+ (unit_t'(term_s1[6]) + unit_t'(term_s1[7])));
		end
	end

	// x^100 = x^64 * x^32 * x^4, one product per stage.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			x2_s3 <= mulq(total_s2, total_s2);
		end
		if (adv[4]) begin
			x4_s4 <= mulq(x2_s3, x2_s3);
		end
		if (adv[5]) begin
			x8_s5 <= mulq(x4_s4, x4_s4);
			x4_s5 <= x4_s4;
		end
		if (adv[6]) begin
			x16_s6 <= mulq(x8_s5, x8_s5);
			x4_s6 <= x4_s5;
		end
		if (adv[7]) begin
			x32_s7 <= mulq(x16_s6, x16_s6);
			x4_s7 <= x4_s6;
		end
		if (adv[8]) begin
			x64_s8 <= mulq(x32_s7, x32_s7);
			x32_s8 <= x32_s7;
			x4_s8 <= x4_s7;
		end
		if (adv[9]) begin
			m_s9 <= mulq(x64_s8, x32_s8);
			x4_s9 <= x4_s8;
		end
		if (adv[10]) begin
			p_s10 <= mulq(m_s9, x4_s9);
		end
	end

	// u = floor((p - lo) * 2^F / span): an estimate by the reciprocal that is at
	// most one low, then one remainder check. The offset is only meaningful
	// inside the window, where it is below the span.
	assign q0_prod = (2 * FRAC_BITS + 1)'(n_s11) * (2 * FRAC_BITS + 1)'(EDGE_RECIP);
	assign rem_next = {n_s13, {FRAC_BITS{1'b0}}} - qd_s13;

	always_ff @(posedge clk) begin
		if (adv[11]) begin
			lo_s11 <= p_s10 <= EDGE_LO;
			hi_s11 <= p_s10 >= EDGE_HI;
			n_s11 <= frac_t'(p_s10 - EDGE_LO);
		end
		if (adv[12]) begin
			q0_s12 <= q0_prod[FRAC_BITS +: FRAC_BITS];
			n_s12 <= n_s11;
			lo_s12 <= lo_s11;
			hi_s12 <= hi_s11;
		end
		if (adv[13]) begin
			qd_s13 <= (2 * FRAC_BITS)'(q0_s12) * (2 * FRAC_BITS)'(EDGE_SPAN);
			q0_s13 <= q0_s12;
			n_s13 <= n_s12;
			lo_s13 <= lo_s12;
			hi_s13 <= hi_s12;
		end
		if (adv[14]) begin
			u_s14 <= q0_s13 + frac_t'(rem_next >= (2 * FRAC_BITS)'(EDGE_SPAN));
			lo_s14 <= lo_s13;
			hi_s14 <= hi_s13;
		end
	end

	// Smoothstep 3u^2 - 2u^3 as (u*u) * (3 - 2u), then scaling to 0..255.
	assign uu_prod = (2 * FRAC_BITS)'(u_s14) * (2 * FRAC_BITS)'(u_s14);
	assign s_prod = (2 * FRAC_BITS + 2)'(uu_s15) * (2 * FRAC_BITS + 2)'(w_s15);
	assign lvl_prod = (FRAC_BITS + 9)'(s_s16) * (FRAC_BITS + 9)'(255);

	always_ff @(posedge clk) begin
		if (adv[15]) begin
			uu_s15 <= uu_prod[FRAC_BITS +: FRAC_BITS];
			w_s15 <= THREE_ONE - (FRAC_BITS + 2)'({u_s14, 1'b0});
			lo_s15 <= lo_s14;
			hi_s15 <= hi_s14;
		end
		if (adv[16]) begin
			priority if (lo_s15) begin
				s_s16 <= '0;
			end else if (hi_s15) begin
				s_s16 <= ONE;
			end else begin
				s_s16 <= s_prod[FRAC_BITS +: FRAC_BITS + 1];
			end
		end
		if (adv[17]) begin
			if (lvl_prod[FRAC_BITS +: 9] > 9'd255) begin
				level_s17 <= 8'd255;
			end else begin
				level_s17 <= lvl_prod[FRAC_BITS +: 8];
			end
		end
	end

endmodule
